@@ hw/rtl/lph_pkg.sv @@
`default_nettype none

package lph_pkg;

    localparam int SLOTS_DEFAULT = 1024;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] FILL_LIMIT_RESET = 11'd768;

    // stream word layouts
    localparam int IN_DATA_W  = KEY_W + VAL_W;                        // key, value
    localparam int OUT_DATA_W = ((VAL_W + COUNT_W + 7) / 8) * 8;      // value, live count
    localparam int OUT_USER_W = 1 + STATUS_W;                         // found, status

    typedef enum logic [MODE_W-1:0] {
        MODE_GET          = 2'd0,
        MODE_PUT          = 2'd1,
        MODE_PUT_IF_EMPTY = 2'd2,
        MODE_REMOVE       = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/lph_ram.sv @@
`default_nettype none

module lph_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/lph_index.sv @@
`default_nettype none

// Home bucket of a key: key mod SLOTS.
module lph_index #(
    parameter  int SLOTS = lph_pkg::SLOTS_DEFAULT,
    localparam int AW    = $clog2(SLOTS)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [lph_pkg::KEY_W-1:0] i_key,
    output logic                          o_done,
    output logic      [AW-1:0]            o_index
);

    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    generate
        if (POW2) begin : g_pow2
            logic          r_done;
            logic [AW-1:0] r_index;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_index <= i_key[AW-1:0];
                end
            end

            assign o_done  = r_done;
            assign o_index = r_index;
        end else begin : g_serial
            // Reduce eight key bits per cycle, most significant first.
            localparam int CHUNK = 8;
            localparam int STEPS = lph_pkg::KEY_W / CHUNK;
            localparam int SW    = $clog2(STEPS);
            localparam logic [AW:0] MODULUS = (AW+1)'(SLOTS);

            logic                      r_busy;
            logic                      r_done;
            logic [SW-1:0]             r_step;
            logic [lph_pkg::KEY_W-1:0] r_shift;
            logic [AW-1:0]             r_rem;
            logic [AW-1:0]             n_rem;

            always_comb begin
                logic [AW:0] t;
                t     = '0;
                n_rem = r_rem;
                for (int j = 0; j < CHUNK; j++) begin
                    t = {n_rem, r_shift[lph_pkg::KEY_W-1-j]};
                    if (t >= MODULUS) begin
                        t = t - MODULUS;
                    end
                    n_rem = t[AW-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_step <= '0;
                    end else if (r_busy) begin
                        r_step <= r_step + 1'b1;
                        if (r_step == SW'(STEPS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
                if (i_start) begin
                    r_shift <= i_key;
                    r_rem   <= '0;
                end else if (r_busy) begin
                    r_shift <= r_shift << CHUNK;
                    r_rem   <= n_rem;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

@@ hw/rtl/linear_probe_hash_table.sv @@
`default_nettype none

// Flow: each accepted word finds its home bucket, then probes P buckets from there, one
//   key/value memory read per probe; the home-bucket reduction is serial when SLOTS is
//   not a power of two.
// One operation at a time: a new word is taken once the result is in the output register.
// Reset: synchronous, active low; afterwards the key memory is swept clear, one bucket per
//   cycle, before the first word is accepted (config writes always taken).
module linear_probe_hash_table #(
    parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_cfg_we,
    input  wire logic [lph_pkg::COUNT_W-1:0]       i_cfg_wdata,    // fill_limit

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [lph_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // key_hash, value_in
    input  wire logic [lph_pkg::MODE_W-1:0]        s_axis_tuser,   // mode

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [lph_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // value_out, live_count, pad
    output logic      [lph_pkg::OUT_USER_W-1:0]    m_axis_tuser    // found, status
);

    localparam int AW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int MW  = (CW > lph_pkg::COUNT_W) ? CW : lph_pkg::COUNT_W;
    localparam int KW  = lph_pkg::KEY_W;
    localparam int VW  = lph_pkg::VAL_W;
    localparam int PAD = lph_pkg::OUT_DATA_W - VW - lph_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    t_state r_state;

    // operation being worked on
    lph_pkg::t_mode           r_mode;
    logic [KW-1:0]            r_key;
    logic [VW-1:0]            r_val;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_cnt;
    logic [AW-1:0]            r_clr_addr;

    // table totals and the fill limit register
    logic [CW-1:0]            r_used;
    logic [CW-1:0]            r_del;
    logic [lph_pkg::COUNT_W-1:0] r_fill;

    // result waiting for the output register
    logic                     r_found;
    logic [VW-1:0]            r_vout;
    lph_pkg::t_status         r_status;

    // output register
    logic                     r_o_valid;
    logic                     r_o_found;
    logic [VW-1:0]            r_o_vout;
    lph_pkg::t_status         r_o_status;
    logic [lph_pkg::COUNT_W-1:0] r_o_live;

    // home bucket unit
    logic                     idx_done;
    logic [AW-1:0]            idx_home;

    // memories: key word with live mark, and value
    logic                     key_we;
    logic [AW-1:0]            key_waddr;
    logic [KW:0]              key_wdata;
    logic [KW:0]              key_rdata;
    logic [AW-1:0]            rd_addr;
    logic                     val_we;
    logic [VW-1:0]            val_rdata;

    // probe decision
    logic                     rd_live;
    logic [KW-1:0]            rd_key;
    logic                     hit;
    logic                     empty;
    logic                     fin;
    logic                     wr_live;
    logic                     inc_used;
    logic                     inc_del;
    logic                     dec_del;
    logic                     n_found;
    logic [VW-1:0]            n_vout;
    lph_pkg::t_status         n_status;
    logic [AW-1:0]            next_idx;
    logic                     lookup;
    logic                     accept;
    logic                     out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_o_valid || m_axis_tready;
    assign lookup   = (r_mode == lph_pkg::MODE_GET) || (r_mode == lph_pkg::MODE_REMOVE);

    lph_index #(
        .SLOTS (SLOTS)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (s_axis_tdata[KW-1:0]),
        .o_done  (idx_done),
        .o_index (idx_home)
    );

    lph_ram #(
        .WIDTH (KW + 1),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    lph_ram #(
        .WIDTH (VW),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_idx),
        .i_wdata (r_val),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    assign rd_live  = key_rdata[KW];
    assign rd_key   = key_rdata[KW-1:0];
    assign hit      = (rd_key == r_key);
    assign empty    = (rd_key == '0);
    assign next_idx = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    // Read the home bucket when it is known, then step one bucket per cycle.
    assign rd_addr = (r_state == S_HASH) ? idx_home : next_idx;

    // Probe step: the read issued last cycle is on the memory outputs.
    always_comb begin
        fin      = 1'b0;
        wr_live  = 1'b0;
        key_we   = 1'b0;
        val_we   = 1'b0;
        inc_used = 1'b0;
        inc_del  = 1'b0;
        dec_del  = 1'b0;
        n_found  = 1'b0;
        n_vout   = '0;
        n_status = lph_pkg::ST_DONE;
        if (r_state == S_PROBE) begin
            fin = hit || empty || (r_cnt == LAST);
            if (lookup) begin
                if (hit && rd_live) begin
                    n_found = 1'b1;
                    n_vout  = val_rdata;
                    if (r_mode == lph_pkg::MODE_REMOVE) begin
                        key_we  = 1'b1;
                        inc_del = 1'b1;
                    end
                end
            end else if (!hit && !empty) begin
                n_status = lph_pkg::ST_FULL;
            end else if (hit && rd_live) begin
                n_found = 1'b1;
                if (r_mode == lph_pkg::MODE_PUT) begin
                    n_vout = val_rdata;
                    val_we = 1'b1;
                end else begin
                    n_status = lph_pkg::ST_PRESENT;
                end
            end else if (hit) begin
                // revive a dead record
                val_we  = 1'b1;
                key_we  = 1'b1;
                wr_live = 1'b1;
                dec_del = (r_del != '0);
            end else if (MW'(r_used) >= MW'(r_fill)) begin
                n_status = lph_pkg::ST_FULL;
            end else begin
                val_we   = 1'b1;
                key_we   = 1'b1;
                wr_live  = 1'b1;
                inc_used = 1'b1;
            end
            // hold memory writes until the probe has settled on this bucket
            if (!fin) begin
                key_we   = 1'b0;
                val_we   = 1'b0;
                inc_used = 1'b0;
                inc_del  = 1'b0;
                dec_del  = 1'b0;
            end
        end
        if (r_state == S_CLEAR) begin
            key_we = 1'b1;
        end
    end

    assign key_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    assign key_wdata = (r_state == S_CLEAR) ? '0 : {wr_live, r_key};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_used     <= '0;
            r_del      <= '0;
            r_fill     <= lph_pkg::FILL_LIMIT_RESET;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fill <= i_cfg_wdata;
            end
            // load a new result word, or drop the one just taken
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (inc_used) begin
                r_used <= r_used + 1'b1;
            end
            if (inc_del) begin
                r_del <= r_del + 1'b1;
            end else if (dec_del) begin
                r_del <= r_del - 1'b1;
            end

            unique case (r_state)
                S_CLEAR: begin
                    // sweep the key memory to empty
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_HASH;
                        r_mode  <= lph_pkg::t_mode'(s_axis_tuser);
                        r_key   <= s_axis_tdata[KW-1:0];
                        r_val   <= s_axis_tdata[KW+VW-1:KW];
                    end
                end
                S_HASH: begin
                    if (r_key == '0) begin
                        // a zero key never matches: answer as an exhausted probe
                        r_found  <= 1'b0;
                        r_vout   <= '0;
                        r_status <= lookup ? lph_pkg::ST_DONE : lph_pkg::ST_FULL;
                        r_state  <= S_DONE;
                    end else if (idx_done) begin
                        r_idx   <= idx_home;
                        r_cnt   <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (fin) begin
                        r_found  <= n_found;
                        r_vout   <= n_vout;
                        r_status <= n_status;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx <= next_idx;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_found  <= r_found;
                        r_o_vout   <= r_vout;
                        r_o_status <= r_status;
                        r_o_live   <= lph_pkg::COUNT_W'(MW'(r_used) - MW'(r_del));
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{PAD{1'b0}}, r_o_live, r_o_vout};
    assign m_axis_tuser  = {r_o_status, r_o_found};

`ifndef NO_ASSERTIONS
    a_del_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_del <= r_used)
        else $error("deleted count exceeds used count");

    a_present_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == lph_pkg::ST_PRESENT) |-> r_o_found)
        else $error("present status without a live entry");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == lph_pkg::ST_FULL) |-> (!r_o_found && r_o_vout == '0))
        else $error("full status carries a found entry");

    a_no_zero_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (key_we && r_state == S_PROBE) |-> (r_key != '0))
        else $error("zero key written to a bucket");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_HASH))
        else $error("accepted word did not start a lookup");
`endif

endmodule

`default_nettype wire
